// File: rtl/core/imsp_pkg.sv
// imsp_pkg: shared types, codes, widths and elaboration-time helpers for the
// image margin sigmoid pad block. No dependencies.
`default_nettype none

package imsp_pkg;

    // defaults for the top-level parameters
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_MARGIN_DEF = 32;
    localparam int WTAB_DEPTH_DEF = 256;

    // fixed field widths
    localparam int DIM_W  = 7;
    localparam int MAR_W  = 6;
    localparam int POS_W  = 8;
    localparam int PIX_W  = 16;
    localparam int SUM_W  = 28;
    localparam int CNT_W  = 14;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 7;

    // shared divider and square root widths
    localparam int DIV_NW = 56;
    localparam int DIV_DW = 24;
    localparam int SQ_W   = 28;
    localparam int SQR_W  = SQ_W / 2;

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_ROWS = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_COLS = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_VM   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_HM   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_REFL = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_AVG  = 3'd5;

    localparam longint unsigned Q31 = 64'h0000_0000_8000_0000;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_DIV, S_LD_WAIT, S_LD_WR, S_LD_END, S_BG_DIV, S_BG_WAIT,
        S_RD_POS, S_RD_MAP, S_RD_MEM, S_RD_SEL, S_ED_DIV, S_ED_WAIT,
        S_CR_SQ, S_CR_SUM, S_CR_MUL, S_CR_KMAX, S_CR_DIV, S_CR_DWAIT,
        S_CR_SQRT, S_CR_SWAIT, S_TAB, S_BL_MUL, S_BL_SUM, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LD_DIV, OP_LD_WR, OP_BG_DIV, OP_BG_WAIT, OP_POS, OP_MAP,
        OP_MEM, OP_SEL, OP_ED_DIV, OP_ED_WAIT, OP_CR_SQ, OP_CR_SUM, OP_CR_MUL,
        OP_CR_KMAX, OP_CR_DIV, OP_CR_SQRT, OP_CR_SWAIT, OP_TAB, OP_BL_MUL,
        OP_BL_SUM, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {ZN_BEFORE, ZN_INSIDE, ZN_AFTER} t_zone;

    typedef struct packed {
        logic accept;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic ld_full;
        logic interior;
        logic corner;
        logic s_ge_den;
        logic div_done;
        logic sq_done;
    } t_stat;

    typedef struct packed {
        t_zone              zone;
        logic [DIM_W-1:0]   src;
        logic [MAR_W-1:0]   enm;
        logic [MAR_W-1:0]   eden;
        logic [MAR_W-1:0]   cnum;
        logic [MAR_W-1:0]   cden;
    } t_axis;

    // exp(-y) in Q31 from a fourth-order series raised to the 64th power
    function automatic longint unsigned f_negexp(input longint unsigned yq);
        longint unsigned t, t2, t3, t4, e;
        t  = yq >> 6;
        t2 = (t * t) >> 31;
        t3 = (t2 * t) >> 31;
        t4 = (t3 * t) >> 31;
        e  = Q31 - t + t2 / 2 - t3 / 6 + t4 / 24;
        for (int i = 0; i < 6; i++) begin
            e = (e * e) >> 31;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/imsp_div.sv
// imsp_div: restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module imsp_div #(
    parameter int NW = 56,
    parameter int DW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quot,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = $clog2(NW);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_run, r_done;
    logic [DW:0]   shv;
    logic          fits;

    // trial subtract of the shifted partial remainder
    assign shv  = {r_rem, r_q[NW-1]};
    assign fits = shv >= {1'b0, r_den};

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            r_q   <= {r_q[NW-2:0], fits};
            r_rem <= fits ? DW'(shv - {1'b0, r_den}) : shv[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/core/imsp_sqrt.sv
// imsp_sqrt: digit-by-digit integer square root, two radicand bits a cycle.
// Depends on imsp_pkg for widths.
`default_nettype none

module imsp_sqrt
    import imsp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SQ_W-1:0]  i_x,
    output logic                  o_done,
    output logic [SQR_W-1:0]      o_root
);
    localparam int CW = $clog2(SQR_W);

    logic [SQ_W-1:0]    r_x;
    logic [SQR_W+1:0]   r_rem;
    logic [SQR_W-1:0]   r_root;
    logic [CW-1:0]      r_cnt;
    logic               r_run, r_done;
    logic [SQR_W+1:0]   remv, trial;
    logic               fits;

    // bring down two bits and try root*4+1
    assign remv  = {r_rem[SQR_W-1:0], r_x[SQ_W-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign fits  = remv >= trial;

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SQR_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // root and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_x    <= {r_x[SQ_W-3:0], 2'b00};
            r_rem  <= fits ? remv - trial : remv;
            r_root <= {r_root[SQR_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: rtl/core/imsp_ctrl.sv
// imsp_ctrl: sequencer for loads, background mean and padded reads.
// Depends on imsp_pkg for state, command and status types.
`default_nettype none

module imsp_ctrl
    import imsp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_opcode,
    input  wire t_stat i_stat,
    output logic      o_busy,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.op     = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_opcode) begin
                        n_state = i_stat.ld_full ? S_RD_POS : S_IDLE;
                    end else begin
                        n_state = i_stat.ld_full ? S_IDLE : S_LD_DIV;
                    end
                end
            end
            S_LD_DIV: begin
                o_cmd.op = OP_LD_DIV;
                n_state  = S_LD_WAIT;
            end
            S_LD_WAIT: begin
                if (i_stat.div_done) n_state = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.op = OP_LD_WR;
                n_state  = S_LD_END;
            end
            S_LD_END: begin
                n_state = i_stat.ld_full ? S_BG_DIV : S_IDLE;
            end
            S_BG_DIV: begin
                o_cmd.op = OP_BG_DIV;
                n_state  = S_BG_WAIT;
            end
            S_BG_WAIT: begin
                o_cmd.op = OP_BG_WAIT;
                if (i_stat.div_done) n_state = S_IDLE;
            end
            S_RD_POS: begin
                o_cmd.op = OP_POS;
                n_state  = S_RD_MAP;
            end
            S_RD_MAP: begin
                o_cmd.op = OP_MAP;
                n_state  = S_RD_MEM;
            end
            S_RD_MEM: begin
                o_cmd.op = OP_MEM;
                n_state  = S_RD_SEL;
            end
            S_RD_SEL: begin
                o_cmd.op = OP_SEL;
                if (i_stat.interior)    n_state = S_EMIT;
                else if (i_stat.corner) n_state = S_CR_SQ;
                else                    n_state = S_ED_DIV;
            end
            S_ED_DIV: begin
                o_cmd.op = OP_ED_DIV;
                n_state  = S_ED_WAIT;
            end
            S_ED_WAIT: begin
                o_cmd.op = OP_ED_WAIT;
                if (i_stat.div_done) n_state = S_TAB;
            end
            S_CR_SQ: begin
                o_cmd.op = OP_CR_SQ;
                n_state  = S_CR_SUM;
            end
            S_CR_SUM: begin
                o_cmd.op = OP_CR_SUM;
                n_state  = S_CR_MUL;
            end
            S_CR_MUL: begin
                o_cmd.op = OP_CR_MUL;
                n_state  = i_stat.s_ge_den ? S_CR_KMAX : S_CR_DIV;
            end
            S_CR_KMAX: begin
                o_cmd.op = OP_CR_KMAX;
                n_state  = S_TAB;
            end
            S_CR_DIV: begin
                o_cmd.op = OP_CR_DIV;
                n_state  = S_CR_DWAIT;
            end
            S_CR_DWAIT: begin
                if (i_stat.div_done) n_state = S_CR_SQRT;
            end
            S_CR_SQRT: begin
                o_cmd.op = OP_CR_SQRT;
                n_state  = S_CR_SWAIT;
            end
            S_CR_SWAIT: begin
                o_cmd.op = OP_CR_SWAIT;
                if (i_stat.sq_done) n_state = S_TAB;
            end
            S_TAB: begin
                o_cmd.op = OP_TAB;
                n_state  = S_BL_MUL;
            end
            S_BL_MUL: begin
                o_cmd.op = OP_BL_MUL;
                n_state  = S_BL_SUM;
            end
            S_BL_SUM: begin
                o_cmd.op = OP_BL_SUM;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/imsp_dp.sv
// imsp_dp: registers, pixel store, weight table, distance math and blend.
// Depends on imsp_pkg, imsp_div and imsp_sqrt.
`default_nettype none

module imsp_dp
    import imsp_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_MARGIN = MAX_MARGIN_DEF,
    parameter int WTAB_DEPTH = WTAB_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic [PIX_W-1:0]  i_pixel_in,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    output logic                   o_valid,
    output logic [PIX_W-1:0]       o_pixel_out,
    output logic [DIM_W-1:0]       o_out_row,
    output logic [DIM_W-1:0]       o_out_col,
    output logic                   o_last_pixel
);
    localparam int D1    = WTAB_DEPTH - 1;
    localparam int KW    = $clog2(WTAB_DEPTH);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam longint unsigned FOUR_D1SQ = 64'(4) * 64'(D1) * 64'(D1);
    localparam int FW    = $clog2(FOUR_D1SQ + 1);
    localparam logic [FW-1:0] FOUR_D1SQ_V = FW'(FOUR_D1SQ);

    // configuration registers
    logic [DIM_W-1:0] r_rows, r_cols;
    logic [MAR_W-1:0] r_vm, r_hm;
    logic             r_refl, r_avg;

    // block state
    logic [CNT_W-1:0] r_load_count;
    logic [SUM_W-1:0] r_sum;
    logic [PIX_W-1:0] r_bg;
    logic [POS_W-1:0] r_row, r_col;

    // per-request payload
    logic [PIX_W-1:0] r_pin, r_src, r_pix;
    t_axis            r_ra, r_ca;
    logic [AW-1:0]    r_addr;
    logic [11:0]      r_rn2, r_cn2, r_rd2, r_cd2;
    logic [24:0]      r_s;
    logic [23:0]      r_den;
    logic [DIV_NW-1:0] r_num;
    logic [KW-1:0]    r_k;
    logic [PIX_W-1:0] r_w;
    logic [31:0]      r_p1;
    logic [32:0]      r_p2;
    logic             r_valid, r_last;
    logic [PIX_W-1:0] r_out_pix;
    logic [DIM_W-1:0] r_out_row, r_out_col;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] wtab [WTAB_DEPTH];

    logic [DIM_W-1:0] rows_c, cols_c;
    logic [MAR_W-1:0] vm_c, hm_c;
    logic [CNT_W-1:0] total, bcnt, cnt;
    logic [POS_W-1:0] prow, pcol;
    logic             last;
    t_axis            ra_n, ca_n;
    t_axis            ed;

    logic              div_start, div_done, sq_start, sq_done;
    logic [DIV_NW-1:0] div_num, div_q;
    logic [DIV_DW-1:0] div_den, div_r;
    logic [SQR_W-1:0]  sq_root;
    logic [SQR_W:0]    sq_half;
    logic [DIM_W-1:0]  ld_r, ld_c;
    logic [33:0]       bl_sum;
    logic [17:0]       bl_pix;

    // weight table, worked out at elaboration
    for (genvar g = 0; g < WTAB_DEPTH; g++) begin : g_wtab
        localparam longint unsigned YQ =
            ((64'(6) * 64'(D1 - g)) << 31) / 64'(D1);
        localparam longint unsigned E = f_negexp(YQ);
        localparam longint unsigned W =
            (((Q31 - E) << 16) + (Q31 + E) / 2) / (Q31 + E);
        assign wtab[g] = (W > 64'd65535) ? 16'hFFFF : 16'(W);
    end

    // margin source and distance terms along one axis
    function automatic t_axis f_axis(input logic [POS_W-1:0] p,
                                     input logic [MAR_W-1:0] m,
                                     input logic [DIM_W-1:0] n,
                                     input logic refl);
        t_axis            a;
        logic [POS_W-1:0] pm, mn, mir, q, nm1;
        pm  = {2'b00, m};
        mn  = pm + {1'b0, n};
        nm1 = {1'b0, n - 7'd1};
        a.zone = ZN_INSIDE;
        a.src  = '0;
        a.enm  = '0;
        a.eden = 6'd1;
        a.cnum = '0;
        a.cden = 6'd1;
        mir = pm - 8'd1 - p;
        q   = p - mn;
        if (p < pm) begin
            a.zone = ZN_BEFORE;
            a.src  = refl ? ((mir > nm1) ? nm1[DIM_W-1:0] : mir[DIM_W-1:0]) : '0;
            a.enm  = MAR_W'(pm - p);
            a.eden = m;
            if (m == 6'd1) begin
                a.cnum = 6'd1;
            end else begin
                a.cnum = mir[MAR_W-1:0];
                a.cden = m - 6'd1;
            end
        end else if (p < mn) begin
            a.src = DIM_W'(p - pm);
        end else begin
            a.zone = ZN_AFTER;
            a.src  = refl ? ((q > nm1) ? '0 : DIM_W'(nm1 - q)) : nm1[DIM_W-1:0];
            a.enm  = q[MAR_W-1:0];
            a.eden = m;
            if (m != 6'd1) begin
                a.cnum = q[MAR_W-1:0];
                a.cden = m - 6'd1;
            end
        end
        return a;
    endfunction

    // clamped geometry
    always_comb begin
        rows_c = (r_rows < 7'd2) ? 7'd2 :
                 ((32'(r_rows) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : r_rows);
        cols_c = (r_cols < 7'd2) ? 7'd2 :
                 ((32'(r_cols) > MAX_COLS) ? DIM_W'(MAX_COLS) : r_cols);
        vm_c   = (r_vm < 6'd1) ? 6'd1 :
                 ((32'(r_vm) > MAX_MARGIN) ? MAR_W'(MAX_MARGIN) : r_vm);
        hm_c   = (r_hm < 6'd1) ? 6'd1 :
                 ((32'(r_hm) > MAX_MARGIN) ? MAR_W'(MAX_MARGIN) : r_hm);
        total  = CNT_W'(rows_c * cols_c);
        bcnt   = CNT_W'({rows_c, 1'b0}) + CNT_W'({cols_c, 1'b0}) - CNT_W'(2);
        cnt    = r_avg ? total : bcnt;
        prow   = {1'b0, rows_c} + {1'b0, vm_c, 1'b0};
        pcol   = {1'b0, cols_c} + {1'b0, hm_c, 1'b0};
        last   = (r_row == prow - 8'd1) && (r_col == pcol - 8'd1);
        ra_n   = f_axis(r_row, vm_c, rows_c, r_refl);
        ca_n   = f_axis(r_col, hm_c, cols_c, r_refl);
        ed     = (r_ra.zone != ZN_INSIDE) ? r_ra : r_ca;
        ld_r   = div_q[DIM_W-1:0];
        ld_c   = div_r[DIM_W-1:0];
        sq_half = ({1'b0, sq_root} + 1'b1) >> 1;
        bl_sum = {2'b00, r_p1} + {1'b0, r_p2} + 34'd32768;
        bl_pix = bl_sum[33:16];
    end

    // shared divider operands
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = 24'd1;
        case (i_cmd.op)
            OP_LD_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_load_count);
                div_den   = DIV_DW'(cols_c);
            end
            OP_BG_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(r_sum) + DIV_NW'(cnt >> 1);
                div_den   = DIV_DW'(cnt);
            end
            OP_ED_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_NW'(32'(D1) * 32'(ed.enm) + 32'(ed.eden >> 1));
                div_den   = DIV_DW'(ed.eden);
            end
            OP_CR_DIV: begin
                div_start = 1'b1;
                div_num   = r_num;
                div_den   = r_den;
            end
            default: ;
        endcase
    end

    assign sq_start = (i_cmd.op == OP_CR_SQRT);

    imsp_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    imsp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (SQ_W'(div_q)),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= 7'd64;
            r_cols       <= 7'd64;
            r_vm         <= 6'd8;
            r_hm         <= 6'd8;
            r_refl       <= 1'b0;
            r_avg        <= 1'b0;
            r_load_count <= '0;
            r_sum        <= '0;
            r_bg         <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    CFG_VM:   r_vm   <= i_cfg_data[MAR_W-1:0];
                    CFG_HM:   r_hm   <= i_cfg_data[MAR_W-1:0];
                    CFG_REFL: r_refl <= i_cfg_data[0];
                    CFG_AVG:  r_avg  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_LD_WR: begin
                    r_load_count <= r_load_count + 1'b1;
                    if (r_avg || ld_r == 7'd0 || ld_r == rows_c - 7'd1 ||
                        ld_c == 7'd0 || ld_c == cols_c - 7'd1) begin
                        r_sum <= r_sum + SUM_W'(r_pin);
                    end
                end
                OP_BG_WAIT: begin
                    if (div_done) begin
                        r_bg <= (div_q > DIV_NW'(65535)) ? 16'hFFFF : div_q[PIX_W-1:0];
                    end
                end
                OP_POS: begin
                    if (r_row >= prow || r_col >= pcol) begin
                        r_row <= '0;
                        r_col <= '0;
                    end
                end
                OP_EMIT: begin
                    r_valid <= 1'b1;
                    if (last) begin
                        r_row        <= '0;
                        r_col        <= '0;
                        r_load_count <= '0;
                        r_sum        <= '0;
                    end else if (r_col + 8'd1 >= pcol) begin
                        r_col <= '0;
                        r_row <= r_row + 8'd1;
                    end else begin
                        r_col <= r_col + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // pixel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LD_WR) begin
            mem[AW'(32'(ld_r) * MAX_COLS + 32'(ld_c))] <= r_pin;
        end
        if (i_cmd.op == OP_MEM) begin
            r_src <= mem[r_addr];
        end
    end

    // request payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_pin <= i_pixel_in;
        case (i_cmd.op)
            OP_MAP: begin
                r_ra   <= ra_n;
                r_ca   <= ca_n;
                r_addr <= AW'(32'(ra_n.src) * MAX_COLS + 32'(ca_n.src));
            end
            OP_SEL:     r_pix <= r_src;
            OP_ED_WAIT: begin
                if (div_done) begin
                    r_k <= (div_q > DIV_NW'(D1)) ? KW'(D1) : div_q[KW-1:0];
                end
            end
            OP_CR_SQ: begin
                r_rn2 <= r_ra.cnum * r_ra.cnum;
                r_rd2 <= r_ra.cden * r_ra.cden;
                r_cn2 <= r_ca.cnum * r_ca.cnum;
                r_cd2 <= r_ca.cden * r_ca.cden;
            end
            OP_CR_SUM: begin
                r_s   <= 25'(r_rn2 * r_cd2) + 25'(r_cn2 * r_rd2);
                r_den <= r_rd2 * r_cd2;
            end
            OP_CR_MUL:  r_num <= DIV_NW'(FOUR_D1SQ_V * r_s);
            OP_CR_KMAX: r_k   <= KW'(D1);
            OP_CR_SWAIT: begin
                if (sq_done) begin
                    r_k <= (sq_half > (SQR_W+1)'(D1)) ? KW'(D1) : sq_half[KW-1:0];
                end
            end
            OP_TAB:    r_w <= wtab[r_k];
            OP_BL_MUL: begin
                r_p1 <= r_w * r_src;
                r_p2 <= (17'h10000 - {1'b0, r_w}) * r_bg;
            end
            OP_BL_SUM: r_pix <= (bl_pix > 18'd65535) ? 16'hFFFF : bl_pix[PIX_W-1:0];
            OP_EMIT: begin
                r_out_pix <= r_pix;
                r_out_row <= r_row[DIM_W-1:0];
                r_out_col <= r_col[DIM_W-1:0];
                r_last    <= last;
            end
            default: ;
        endcase
    end

    // status back to the sequencer
    always_comb begin
        o_stat.ld_full  = r_load_count >= total;
        o_stat.interior = (r_ra.zone == ZN_INSIDE) && (r_ca.zone == ZN_INSIDE);
        o_stat.corner   = (r_ra.zone != ZN_INSIDE) && (r_ca.zone != ZN_INSIDE);
        o_stat.s_ge_den = {1'b0, r_den} <= r_s;
        o_stat.div_done = div_done;
        o_stat.sq_done  = sq_done;
    end

    assign o_valid      = r_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_last_pixel = r_last;

endmodule

`default_nettype wire

// File: rtl/core/image_margin_sigmoid_pad_top.sv
// image_margin_sigmoid_pad_top: top level, sequencer plus datapath.
// Depends on imsp_pkg, imsp_ctrl and imsp_dp.
`default_nettype none

// Loads an image in raster order (opcode 0) and then returns the padded image
// one pixel per read request (opcode 1). A request is taken when start is high
// and busy is low; the block works on one request at a time. Each load
// splits the load count into row and column through the serial divider; the
// final load also works out the background mean through the same divider. An
// interior pixel needs no divide, an edge margin pixel one divide and a corner
// pixel one divide plus the square root, or neither when the corner distance
// clamps to one. Each result sits on the outputs for one cycle under o_valid;
// the receiver cannot stall it. Reads before the image is complete and loads
// after it are dropped.
module image_margin_sigmoid_pad_top
    import imsp_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_MARGIN = MAX_MARGIN_DEF,
    parameter int WTAB_DEPTH = WTAB_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_opcode,
    input  wire logic [PIX_W-1:0]  i_pixel_in,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    output logic                   o_valid,
    output logic [PIX_W-1:0]       o_pixel_out,
    output logic [DIM_W-1:0]       o_out_row,
    output logic [DIM_W-1:0]       o_out_col,
    output logic                   o_last_pixel
);
    t_cmd  cmd;
    t_stat stat;

    // sequencer
    imsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // datapath
    imsp_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_MARGIN (MAX_MARGIN),
        .WTAB_DEPTH (WTAB_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pixel_in   (i_pixel_in),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_pixel_out  (o_pixel_out),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_last_pixel (o_last_pixel)
    );

endmodule

`default_nettype wire

// File: test/image_margin_sigmoid_pad_top_test.sv
// image_margin_sigmoid_pad_top_test: self-checking bench for the padding block.
// Uses imsp_pkg and image_margin_sigmoid_pad_top; predicts every padded pixel.
module image_margin_sigmoid_pad_top_test;
    import imsp_pkg::*;

    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_READ = 1'b1;
    localparam int LUT_N    = WTAB_DEPTH_DEF;
    localparam int IMG_STRIDE = MAX_COLS_DEF;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 3000;
    localparam int ITEM_GOAL     = 650;

    typedef struct {
        bit               op;
        logic [PIX_W-1:0] pix;
    } pad_req_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             last;
    } padded_px_t;

    typedef struct {
        t_zone           zone;
        int              src;
        longint unsigned en, ed, cn, cd;
    } axis_pos_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_opcode;
    logic [PIX_W-1:0]  i_pixel_in;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;
    logic              o_valid;
    logic [PIX_W-1:0]  o_pixel_out;
    logic [DIM_W-1:0]  o_out_row;
    logic [DIM_W-1:0]  o_out_col;
    logic              o_last_pixel;

    image_margin_sigmoid_pad_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_pixel_in(i_pixel_in),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_pixel_out(o_pixel_out), .o_out_row(o_out_row),
        .o_out_col(o_out_col), .o_last_pixel(o_last_pixel)
    );

    // predictor state
    logic [15:0]     blend_lut [LUT_N];
    logic [15:0]     img_mem [MAX_ROWS_DEF*MAX_COLS_DEF];
    int unsigned     ld_cnt, luma_acc, bg_level, em_row, em_col;
    int unsigned     cfg_rows, cfg_cols, cfg_vm, cfg_hm, cfg_refl, cfg_avg;

    pad_req_t        pending_reqs[$];
    padded_px_t      expected_px[$];
    int              n_errors;
    int              n_pushed;
    int              gap_left;
    bit              calm;
    bit              taken;
    int              stall_cnt;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned clampi(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // exp(-y) in Q31 from a truncated series raised to the 64th power
    function automatic longint unsigned exp_neg(longint unsigned y);
        longint unsigned a, a2, a3, a4, r;
        a  = y >> 6;
        a2 = (a * a) >> 31;
        a3 = (a2 * a) >> 31;
        a4 = (a3 * a) >> 31;
        r  = 64'h8000_0000 - a + a2 / 2 - a3 / 6 + a4 / 24;
        repeat (6) r = (r * r) >> 31;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // position along one axis: zone, source index and distance ratios
    function automatic axis_pos_t locate(int unsigned p, int unsigned m, int unsigned n, bit refl);
        axis_pos_t a;
        int unsigned mir, q;
        a = '{ZN_INSIDE, 0, 0, 1, 0, 1};
        if (p < m) begin
            mir = m - 1 - p;
            a.zone = ZN_BEFORE;
            a.src  = refl ? (mir > n - 1 ? n - 1 : mir) : 0;
            a.en   = m - p;
            a.ed   = m;
            if (m == 1) begin
                a.cn = 1;
            end else begin
                a.cn = m - 1 - p;
                a.cd = m - 1;
            end
        end else if (p < m + n) begin
            a.src = p - m;
        end else begin
            q = p - m - n;
            a.zone = ZN_AFTER;
            a.src  = refl ? (q > n - 1 ? 0 : n - 1 - q) : n - 1;
            a.en   = q;
            a.ed   = m;
            if (m != 1) begin
                a.cn = q;
                a.cd = m - 1;
            end
        end
        return a;
    endfunction

    // apply one accepted request to the predictor
    task automatic apply_request(input pad_req_t rq);
        int unsigned rows, cols, vm, hm, total, prow, pcol, r, c, cnt;
        longint unsigned d1, s, den, kk, w, src, pix;
        axis_pos_t ra, ca;
        padded_px_t px;
        rows  = clampi(cfg_rows, 2, MAX_ROWS_DEF);
        cols  = clampi(cfg_cols, 2, MAX_COLS_DEF);
        vm    = clampi(cfg_vm, 1, MAX_MARGIN_DEF);
        hm    = clampi(cfg_hm, 1, MAX_MARGIN_DEF);
        total = rows * cols;
        prow  = rows + 2 * vm;
        pcol  = cols + 2 * hm;
        d1    = LUT_N - 1;
        if (rq.op == CMD_LOAD) begin
            if (ld_cnt < total) begin
                r = ld_cnt / cols;
                c = ld_cnt % cols;
                img_mem[r * IMG_STRIDE + c] = rq.pix;
                if (cfg_avg != 0 || r == 0 || r == rows - 1 || c == 0 || c == cols - 1)
                    luma_acc = (luma_acc + rq.pix) & 32'h0FFF_FFFF;
                ld_cnt++;
                if (ld_cnt == total) begin
                    cnt = cfg_avg != 0 ? total : 2 * (rows + cols) - 2;
                    bg_level = (luma_acc + cnt / 2) / cnt;
                    if (bg_level > 65535) bg_level = 65535;
                end
            end
        end else if (ld_cnt >= total) begin
            if (em_row >= prow || em_col >= pcol) begin
                em_row = 0;
                em_col = 0;
            end
            ra  = locate(em_row, vm, rows, cfg_refl != 0);
            ca  = locate(em_col, hm, cols, cfg_refl != 0);
            src = img_mem[ra.src * IMG_STRIDE + ca.src];
            if (ra.zone == ZN_INSIDE && ca.zone == ZN_INSIDE) begin
                pix = src;
            end else begin
                if (ra.zone != ZN_INSIDE && ca.zone != ZN_INSIDE) begin
                    // corner: clamped euclidean distance
                    s   = ra.cn * ra.cn * ca.cd * ca.cd + ca.cn * ca.cn * ra.cd * ra.cd;
                    den = ra.cd * ra.cd * ca.cd * ca.cd;
                    if (s >= den) begin
                        kk = d1;
                    end else begin
                        kk = (int_sqrt((4 * d1 * d1 * s) / den) + 1) >> 1;
                    end
                end else if (ra.zone != ZN_INSIDE) begin
                    kk = (d1 * ra.en + ra.ed / 2) / ra.ed;
                end else begin
                    kk = (d1 * ca.en + ca.ed / 2) / ca.ed;
                end
                if (kk > d1) kk = d1;
                w   = blend_lut[kk];
                pix = (w * src + (65536 - w) * bg_level + 32768) >> 16;
                if (pix > 65535) pix = 65535;
            end
            px.pix  = pix[15:0];
            px.row  = em_row[6:0];
            px.col  = em_col[6:0];
            px.last = (em_row == prow - 1) && (em_col == pcol - 1);
            expected_px.push_back(px);
            if (px.last) begin
                em_row   = 0;
                em_col   = 0;
                ld_cnt   = 0;
                luma_acc = 0;
            end else if (em_col + 1 >= pcol) begin
                em_col = 0;
                em_row++;
            end else begin
                em_col++;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic push_req(input bit op, input logic [15:0] v);
        pending_reqs.push_back('{op, v});
        n_pushed++;
    endtask

    // register write while the block is idle
    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int unsigned v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[CFG_DW-1:0];
        case (idx)
            CFG_ROWS: cfg_rows = v & 7'h7F;
            CFG_COLS: cfg_cols = v & 7'h7F;
            CFG_VM:   cfg_vm   = v & 6'h3F;
            CFG_HM:   cfg_hm   = v & 6'h3F;
            CFG_REFL: cfg_refl = v & 1;
            CFG_AVG:  cfg_avg  = v & 1;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // queue the rest of the image (reads up to read_cap), with ignored noise mixed in
    task automatic queue_image(input int read_cap);
        int unsigned rows, cols, vm, hm, total, prow, pcol, left;
        int i;
        rows  = clampi(cfg_rows, 2, MAX_ROWS_DEF);
        cols  = clampi(cfg_cols, 2, MAX_COLS_DEF);
        vm    = clampi(cfg_vm, 1, MAX_MARGIN_DEF);
        hm    = clampi(cfg_hm, 1, MAX_MARGIN_DEF);
        total = rows * cols;
        prow  = rows + 2 * vm;
        pcol  = cols + 2 * hm;
        for (i = ld_cnt; i < total; i++) begin
            if ($urandom_range(0, 9) == 0) push_req(CMD_READ, 16'($urandom_range(0, 65535)));
            push_req(CMD_LOAD, rand_pixel());
        end
        if (em_row >= prow || em_col >= pcol) left = prow * pcol;
        else left = prow * pcol - (em_row * pcol + em_col);
        if (read_cap > 0 && read_cap < left) left = read_cap;
        for (i = 0; i < left; i++) begin
            if ($urandom_range(0, 19) == 0) push_req(CMD_LOAD, 16'($urandom_range(0, 65535)));
            push_req(CMD_READ, 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || start || expected_px.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            apply_request('{i_opcode, i_pixel_in});
            taken = 1'b1;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!(start && !taken)) begin
            taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                pad_req_t rq;
                rq = pending_reqs.pop_front();
                start      <= 1'b1;
                i_opcode   <= rq.op;
                i_pixel_in <= rq.pix;
                gap_left   = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_px.size() == 0) begin
                $error("unexpected pixel row %0d col %0d", o_out_row, o_out_col);
                n_errors++;
            end else begin
                padded_px_t px;
                px = expected_px.pop_front();
                if (o_pixel_out !== px.pix) begin
                    $error("pixel_out expected %0d got %0d", px.pix, o_pixel_out);
                    n_errors++;
                end
                if (o_out_row !== px.row) begin
                    $error("out_row expected %0d got %0d", px.row, o_out_row);
                    n_errors++;
                end
                if (o_out_col !== px.col) begin
                    $error("out_col expected %0d got %0d", px.col, o_out_col);
                    n_errors++;
                end
                if (o_last_pixel !== px.last) begin
                    $error("last_pixel expected %0d got %0d", px.last, o_last_pixel);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on lack of progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("image_margin_sigmoid_pad_top_test: errors");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        longint unsigned d1, y, e, w;
        d1 = LUT_N - 1;
        // blend weight table
        for (int k = 0; k < LUT_N; k++) begin
            y = ((64'd6 * (d1 - k)) << 31) / d1;
            e = exp_neg(y);
            w = (((64'h8000_0000 - e) << 16) + (64'h8000_0000 + e) / 2) / (64'h8000_0000 + e);
            blend_lut[k] = w > 65535 ? 16'hFFFF : w[15:0];
        end
        ld_cnt = 0; luma_acc = 0; bg_level = 0; em_row = 0; em_col = 0;
        cfg_rows = 64; cfg_cols = 64; cfg_vm = 8; cfg_hm = 8; cfg_refl = 0; cfg_avg = 0;
        n_errors = 0; n_pushed = 0; gap_left = 0; calm = 1'b0; taken = 1'b0;
        stall_cnt = 0;
        i_rst_n = 1'b0; start = 1'b0; i_opcode = 1'b0; i_pixel_in = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: smallest image, unit margins, reflect, pixel extremes
        cfg_write(CFG_ROWS, 2);
        cfg_write(CFG_COLS, 2);
        cfg_write(CFG_VM, 1);
        cfg_write(CFG_HM, 1);
        cfg_write(CFG_REFL, 1);
        cfg_write(CFG_AVG, 0);
        push_req(CMD_READ, 16'h1234);
        push_req(CMD_LOAD, 16'h0000);
        push_req(CMD_LOAD, 16'hFFFF);
        push_req(CMD_LOAD, 16'hAAAA);
        push_req(CMD_LOAD, 16'h5555);
        push_req(CMD_LOAD, 16'h7777);
        queue_image(0);
        settle();

        // out-of-range register values clamp: tallest image, thinnest margins
        calm = 1'b1;
        cfg_write(CFG_ROWS, 127);
        cfg_write(CFG_COLS, 0);
        cfg_write(CFG_VM, 0);
        cfg_write(CFG_HM, 0);
        cfg_write(CFG_AVG, 1);
        queue_image(0);
        settle();
        calm = 1'b0;

        // widest margins, mirror clamped; partial pass then shrink margins
        cfg_write(CFG_ROWS, 2);
        cfg_write(CFG_COLS, 2);
        cfg_write(CFG_VM, 63);
        cfg_write(CFG_HM, 32);
        cfg_write(CFG_AVG, 0);
        queue_image(70);
        settle();
        cfg_write(CFG_VM, 1);
        cfg_write(CFG_HM, 2);
        cfg_write(CFG_REFL, 0);
        queue_image(0);
        settle();

        // random small images, full passes
        while (n_pushed < ITEM_GOAL) begin
            calm = $urandom_range(0, 3) == 0;
            cfg_write(CFG_ROWS, $urandom_range(0, 9) == 0 ? $urandom_range(6, 9)
                                                        : $urandom_range(2, 5));
            cfg_write(CFG_COLS, $urandom_range(0, 9) == 0 ? $urandom_range(6, 9)
                                                        : $urandom_range(2, 5));
            cfg_write(CFG_VM, $urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                      : $urandom_range(1, 4));
            cfg_write(CFG_HM, $urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                      : $urandom_range(1, 4));
            cfg_write(CFG_REFL, $urandom_range(0, 1));
            cfg_write(CFG_AVG, $urandom_range(0, 1));
            queue_image(0);
            settle();
        end

        if (n_errors == 0) begin
            $display("image_margin_sigmoid_pad_top_test: clean");
        end else begin
            $display("image_margin_sigmoid_pad_top_test: errors");
        end
        $finish;
    end

endmodule
